[src/fmpf_pkg.sv]
// Shared types and constants for the first-match packet filter.
package fmpf_pkg;

   // Default number of rule slots.
   localparam int RULE_SLOTS_DEFAULT = 32;

   // Command codes carried in the request tuser field.
   typedef enum logic [1:0] {
      CMD_CHECK  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

   // A rule whose direction is this value matches both directions.
   localparam logic [1:0] DIR_BOTH = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_FILTER_ENABLE = 1'd0;
   localparam logic [0:0] CSR_DEFAULT_DROP  = 1'd1;

   // One stored rule (also used as the lookup key of a packet).
   typedef struct packed {
      logic        act;
      logic [15:0] port;
      logic [31:0] addr;
      logic        any_proto;
      logic [7:0]  proto;
      logic [1:0]  dir;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

endpackage

[src/fmpf_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module fmpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[src/fmpf_match.sv]
// Compares one stored rule against a packet key.
module fmpf_match (
   input  fmpf_pkg::rule_type rule,
   input  fmpf_pkg::rule_type pkt,
   output logic               hit
);
   import fmpf_pkg::*;

   logic dir_ok;
   logic proto_ok;
   logic addr_ok;
   logic port_ok;

   // Each field either matches exactly or is a wildcard in the rule.
   assign dir_ok   = (rule.dir == DIR_BOTH) || (rule.dir == pkt.dir);
   assign proto_ok = rule.any_proto || (rule.proto == pkt.proto);
   assign addr_ok  = (rule.addr == 32'd0) || (rule.addr == pkt.addr);
   assign port_ok  = (rule.port == 16'd0) || (rule.port == pkt.port);
   assign hit      = dir_ok && proto_ok && addr_ok && port_ok;

endmodule

[src/first_match_packet_filter_unit.sv]
// First-match packet filter: an enabled check scans the rule slots, an add searches for a free
// slot, and a delete, clear or disabled check goes straight to the reply state. One command is in
// flight at a time and the next is accepted in the cycle after the result is loaded; a result
// still waiting on the response channel stalls the reply.
// The scan reads one rule slot per cycle from a memory with a registered read port.
// Synchronous reset clears the valid flags, counters and control registers, not the rule memory.
module first_match_packet_filter_unit #(
   parameter int RULE_SLOTS = fmpf_pkg::RULE_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: direction[1:0], protocol[9:2], protocol_wildcard[10], address[42:11],
   //        port_number[58:43], rule_action[59], slot[65:60], zero fill[71:66]
   input  logic [71:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: drop_packet[0], status[2:1], slot_out[7:3], dropped_total[39:8],
   //        passed_total[71:40], rule_total[77:72], zero fill[79:78]
   output logic [79:0] rsp_tdata,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_wdata
);
   import fmpf_pkg::*;

   localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_REPLY
   } state_type;

   state_type              state_ff, state_in;
   rule_type               key_ff, key_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic                   cmp_ff, cmp_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [RULE_SLOTS-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [31:0]            drop_cnt_ff, drop_cnt_in;
   logic [31:0]            pass_cnt_ff, pass_cnt_in;
   logic                   en_ff, en_in;
   logic                   ddrop_ff, ddrop_in;
   logic                   res_drop_ff, res_drop_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [79:0]            rsp_data_ff, rsp_data_in;

   logic [SLOT_W-1:0]      iss_idx;
   logic                   iss_done;
   logic                   out_free;
   logic                   ram_we;
   rule_type               ram_rdata;
   logic                   rule_hit;
   cmd_type                req_cmd;
   rule_type               req_rule;
   logic [CMP_W-1:0]       del_wide;
   logic [SLOT_W-1:0]      del_idx;
   logic                   del_ok;

   // Request payload unpacking.
   assign req_cmd            = cmd_type'(req_tuser[1:0]);
   assign req_rule.dir       = req_tdata[1:0];
   assign req_rule.proto     = req_tdata[9:2];
   assign req_rule.any_proto = req_tdata[10];
   assign req_rule.addr      = req_tdata[42:11];
   assign req_rule.port      = req_tdata[58:43];
   assign req_rule.act       = req_tdata[59];

   // Delete slot range check and index.
   assign del_wide = CMP_W'(req_tdata[65:60]);
   assign del_idx  = del_wide[SLOT_W-1:0];
   assign del_ok   = (del_wide < CMP_W'(RULE_SLOTS)) && valid_ff[del_idx];

   assign iss_idx  = iss_ff[SLOT_W-1:0];
   assign iss_done = (iss_ff == CNT_W'(RULE_SLOTS));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Rule memory: written on add, read one slot per cycle during a check.
   fmpf_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULE_SLOTS)
   ) u_rule_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (iss_idx),
      .wdata (key_ff),
      .raddr (iss_idx),
      .rdata (ram_rdata)
   );

   // Match of the slot read in the previous cycle against the packet.
   fmpf_match u_match (
      .rule (ram_rdata),
      .pkt  (key_ff),
      .hit  (rule_hit)
   );

   // Command sequencer, table bookkeeping and counters.
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      iss_in        = iss_ff;
      cmp_in        = cmp_ff;
      cmp_vld_in    = cmp_vld_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      drop_cnt_in   = drop_cnt_ff;
      pass_cnt_in   = pass_cnt_ff;
      en_in         = en_ff;
      ddrop_in      = ddrop_ff;
      res_drop_in   = res_drop_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in        = req_rule;
               iss_in        = '0;
               cmp_in        = 1'b0;
               cmp_vld_in    = 1'b0;
               res_drop_in   = 1'b0;
               res_status_in = STATUS_OK;
               res_slot_in   = '0;
               case (req_cmd)
                  CMD_CHECK: begin
                     state_in = en_ff ? ST_SCAN : ST_REPLY;
                  end
                  CMD_ADD: begin
                     state_in = ST_ADD;
                  end
                  CMD_DELETE: begin
                     if (del_ok) begin
                        valid_in[del_idx] = 1'b0;
                        if (used_ff != '0) begin
                           used_in = used_ff - CNT_W'(1);
                        end
                     end else begin
                        res_status_in = STATUS_BAD_SLOT;
                     end
                     state_in = ST_REPLY;
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                     used_in  = '0;
                     state_in = ST_REPLY;
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (cmp_ff && cmp_vld_ff && rule_hit) begin
               // First matching rule decides.
               res_drop_in = ram_rdata.act;
               if (ram_rdata.act) begin
                  drop_cnt_in = drop_cnt_ff + 32'd1;
               end else begin
                  pass_cnt_in = pass_cnt_ff + 32'd1;
               end
               state_in = ST_REPLY;
            end else if (iss_done && !cmp_ff) begin
               // No rule matched: default policy.
               res_drop_in = ddrop_ff;
               if (ddrop_ff) begin
                  drop_cnt_in = drop_cnt_ff + 32'd1;
               end else begin
                  pass_cnt_in = pass_cnt_ff + 32'd1;
               end
               state_in = ST_REPLY;
            end else if (!iss_done) begin
               cmp_in     = 1'b1;
               cmp_vld_in = valid_ff[iss_idx];
               iss_in     = iss_ff + CNT_W'(1);
            end else begin
               cmp_in = 1'b0;
            end
         end

         ST_ADD: begin
            if (iss_done) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_REPLY;
            end else if (!valid_ff[iss_idx]) begin
               ram_we            = 1'b1;
               valid_in[iss_idx] = 1'b1;
               used_in           = used_ff + CNT_W'(1);
               res_slot_in       = iss_idx;
               state_in          = ST_REPLY;
            end else begin
               iss_in = iss_ff + CNT_W'(1);
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, 6'(used_ff), pass_cnt_ff, drop_cnt_ff,
                               5'(res_slot_ff), res_status_ff, res_drop_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ENABLE: en_in    = csr_wdata[0];
            CSR_DEFAULT_DROP:  ddrop_in = csr_wdata[0];
            default:           en_in    = en_ff;
         endcase
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         iss_ff       <= '0;
         valid_ff     <= '0;
         used_ff      <= '0;
         drop_cnt_ff  <= '0;
         pass_cnt_ff  <= '0;
         en_ff        <= 1'b0;
         ddrop_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_ff        <= cmp_in;
         cmp_vld_ff    <= cmp_vld_in;
         iss_ff        <= iss_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         drop_cnt_ff   <= drop_cnt_in;
         pass_cnt_ff   <= pass_cnt_in;
         en_ff         <= en_in;
         ddrop_ff      <= ddrop_in;
         rsp_valid_ff  <= rsp_valid_in;
         key_ff        <= key_in;
         res_drop_ff   <= res_drop_in;
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // The rule count always equals the number of occupied slots.
   assert property (@(posedge clock) disable iff (reset)
      used_ff == CNT_W'($countones(valid_ff)))
      else $error("rule count out of step with slot valid flags");

   // An accepted command always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted command did not start");

   // The scan pointer never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      iss_ff <= CNT_W'(RULE_SLOTS))
      else $error("scan pointer beyond table");

endmodule
